// File: rtl/hwt_pkg.sv
// Shared types, codes and constants of the hashing whitespace tokenizer.
package hwt_pkg;

	// field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned MOD_W   = 17;
	localparam int unsigned MAXT_W  = 16;
	localparam int unsigned IDX_W   = 2;

	// modulo unit: dividend is at most h*31 + byte with h < 2^16
	localparam int unsigned REM_W   = 21;
	localparam int unsigned K_W     = 4;
	localparam int unsigned DSH_W   = MOD_W + 13;
	// top quotient bit when the running hash may exceed the modulus
	localparam logic [K_W-1:0] K_WIDE   = 4'd12;
	// top quotient bit when the running hash is below the modulus
	localparam logic [K_W-1:0] K_NARROW = 4'd4;

	// hash and modulus limits
	localparam logic [4:0]       HASH_MULT = 5'd31;
	localparam logic [MOD_W-1:0] MOD_MIN   = 17'd256;
	localparam logic [MOD_W-1:0] MOD_MAX   = 17'd65536;

	// register indexes and reset values
	localparam logic [IDX_W-1:0]  REG_VOCAB_SIZE = 2'd0;
	localparam logic [IDX_W-1:0]  REG_MAX_TOKENS = 2'd1;
	localparam logic [MOD_W-1:0]  VOCAB_RESET    = 17'd10000;
	localparam logic [MAXT_W-1:0] MAXT_RESET     = 16'd512;

	// token ids and kinds
	localparam logic [ID_W-1:0]   BEGIN_ID   = 16'd2;
	localparam logic [ID_W-1:0]   END_ID     = 16'd3;
	localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	// separators
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} text_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   tok_id;
		logic [KIND_W-1:0] token_kind;
		logic [POS_W-1:0]  position;
		logic              last_of_run;
	} token_word_t;

	// sequencer to modulo unit
	typedef struct packed {
		logic             start;
		logic [REM_W-1:0] dividend;
		logic [K_W-1:0]   k_start;
	} mod_req_t;

	// modulo unit to sequencer
	typedef struct packed {
		logic            done;
		logic [ID_W-1:0] rem;
	} mod_rsp_t;

endpackage

// File: rtl/hashing_whitespace_tokenizer_top.sv
// Top level: byte sequencer, token hold and output register of the tokenizer.
//
//  channel  dir  handshake            word
//  text     in   text_valid/stall     text_word_t (text_byte, end_of_text)
//  token    out  token_valid/stall    token_word_t (id, kind, position, last)
//  cfg      in   cfg_valid/ready      cfg_index, cfg_data (always ready)
//
// A word byte passes accept, setup, 5 steps of the shared modulo unit, its
// done response and a closing state; 13 steps instead of 5 when a modulus
// change left the hash too big. A separator passes accept, setup, flush and
// a closing state, plus one modulo run when a modulus change left the hash
// too big. Each token adds its own emit state. Reset clears control state;
// the modulus starts at 10000. A stalled token output holds back the
// sequencer whenever the held token cannot move on as the output register is full.
module hashing_whitespace_tokenizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          text_valid,
	output logic                          text_stall,
	input  hwt_pkg::text_word_t           text_word,
	output logic                          token_valid,
	input  logic                          token_stall,
	output hwt_pkg::token_word_t          token_word,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hwt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [hwt_pkg::MOD_W-1:0]     cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_BEGIN = 8'b0000_0010,
		S_BODY  = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_FLUSH = 8'b0001_0000,
		S_WEMIT = 8'b0010_0000,
		S_END   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t                         state_q;
	logic [hwt_pkg::MOD_W-1:0]      vocab_q;
	logic [hwt_pkg::MAXT_W-1:0]     maxt_q;
	logic                           inside_q;
	logic                           wopen_q;
	logic [hwt_pkg::ID_W-1:0]       hash_q;
	logic [hwt_pkg::POS_W-1:0]      tok_q;
	logic [hwt_pkg::BYTE_W-1:0]     byte_q;
	logic                           last_q;
	logic                           flushing_q;
	logic [hwt_pkg::ID_W-1:0]       wval_q;
	logic                           hold_v_q;
	hwt_pkg::token_word_t           hold_q;
	logic                           out_v_q;
	hwt_pkg::token_word_t           out_q;

	logic [hwt_pkg::MOD_W-1:0]      modulus;
	logic                           hash_big;
	logic                           is_sep;
	logic [hwt_pkg::REM_W-1:0]      hash_ext;
	hwt_pkg::mod_req_t              mreq;
	hwt_pkg::mod_rsp_t              mrsp;
	logic                           emit_act;
	logic                           emit_drop;
	logic                           emit_go;
	logic [hwt_pkg::ID_W-1:0]       emit_id;
	logic [hwt_pkg::KIND_W-1:0]     emit_kind;
	logic                           out_free;
	logic                           push;
	hwt_pkg::token_word_t           push_word;

	assign cfg_ready  = 1'b1;
	assign text_stall = (state_q != S_IDLE);

	// clamped modulus
	always_comb begin
		if (vocab_q < hwt_pkg::MOD_MIN) begin
			modulus = hwt_pkg::MOD_MIN;
		end else if (vocab_q > hwt_pkg::MOD_MAX) begin
			modulus = hwt_pkg::MOD_MAX;
		end else begin
			modulus = vocab_q;
		end
	end

	assign hash_big = {1'b0, hash_q} >= modulus;
	assign is_sep   = (byte_q == hwt_pkg::CH_SPACE) || (byte_q == hwt_pkg::CH_TAB) ||
	                  (byte_q == hwt_pkg::CH_NL);
	assign hash_ext = {{(hwt_pkg::REM_W - hwt_pkg::ID_W){1'b0}}, hash_q};

	// modulo unit requests: hash step from body, reduction from flush
	always_comb begin
		mreq.start    = 1'b0;
		mreq.dividend = hash_ext;
		mreq.k_start  = hwt_pkg::K_WIDE;
		if (state_q == S_BODY && !is_sep) begin
			mreq.start    = 1'b1;
			mreq.dividend = (hash_ext << 5) - hash_ext +
			                {{(hwt_pkg::REM_W - hwt_pkg::BYTE_W){1'b0}}, byte_q};
			mreq.k_start  = hash_big ? hwt_pkg::K_WIDE : hwt_pkg::K_NARROW;
		end else if (state_q == S_FLUSH && wopen_q && hash_big) begin
			mreq.start    = 1'b1;
		end
	end

	hwt_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.modulus (modulus),
		.rsp     (mrsp)
	);

	// token emission
	always_comb begin
		emit_act  = (state_q == S_BEGIN) || (state_q == S_WEMIT) || (state_q == S_END);
		emit_id   = hwt_pkg::BEGIN_ID;
		emit_kind = hwt_pkg::KIND_BEGIN;
		if (state_q == S_WEMIT) begin
			emit_id   = (wval_q == '0) ? {{(hwt_pkg::ID_W-1){1'b0}}, 1'b1} : wval_q;
			emit_kind = hwt_pkg::KIND_WORD;
		end else if (state_q == S_END) begin
			emit_id   = hwt_pkg::END_ID;
			emit_kind = hwt_pkg::KIND_END;
		end
		out_free  = !out_v_q || !token_stall;
		emit_drop = tok_q >= maxt_q;
		emit_go   = emit_drop || !hold_v_q || out_free;
	end

	// held token goes out when a newer one replaces it or the byte ends
	always_comb begin
		push      = 1'b0;
		push_word = hold_q;
		if (emit_act && !emit_drop && hold_v_q && out_free) begin
			push = 1'b1;
		end else if (state_q == S_DONE && hold_v_q && out_free) begin
			push                  = 1'b1;
			push_word.last_of_run = 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= hwt_pkg::VOCAB_RESET;
			maxt_q  <= hwt_pkg::MAXT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hwt_pkg::REG_VOCAB_SIZE: vocab_q <= cfg_data;
				hwt_pkg::REG_MAX_TOKENS: maxt_q  <= cfg_data[hwt_pkg::MAXT_W-1:0];
				default: ;
			endcase
		end
	end

	// byte latch and word value
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && text_valid) begin
			byte_q <= text_word.text_byte;
			last_q <= text_word.end_of_text;
		end
		if (state_q == S_FLUSH) begin
			wval_q <= hash_q;
		end else if (state_q == S_DIV && mrsp.done) begin
			wval_q <= mrsp.rem;
		end
		if (emit_act && emit_go && !emit_drop) begin
			hold_q.tok_id      <= emit_id;
			hold_q.token_kind  <= emit_kind;
			hold_q.position    <= tok_q;
			hold_q.last_of_run <= 1'b0;
		end
		if (push) begin
			out_q <= push_word;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			inside_q   <= 1'b0;
			wopen_q    <= 1'b0;
			hash_q     <= '0;
			tok_q      <= '0;
			flushing_q <= 1'b0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			// output register
			if (push) begin
				out_v_q <= 1'b1;
			end else if (!token_stall) begin
				out_v_q <= 1'b0;
			end
			// the end token clears the count below instead
			if (emit_act && emit_go && !emit_drop) begin
				hold_v_q <= 1'b1;
				if (state_q != S_END) begin
					tok_q <= tok_q + 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (text_valid) begin
						if (!inside_q) begin
							inside_q <= 1'b1;
							wopen_q  <= 1'b0;
							hash_q   <= '0;
							tok_q    <= '0;
							state_q  <= S_BEGIN;
						end else begin
							state_q  <= S_BODY;
						end
					end
				end
				S_BEGIN: begin
					if (emit_go) begin
						state_q <= S_BODY;
					end
				end
				S_BODY: begin
					if (is_sep) begin
						state_q <= S_FLUSH;
					end else begin
						flushing_q <= 1'b0;
						state_q    <= S_DIV;
					end
				end
				S_DIV: begin
					if (mrsp.done) begin
						if (flushing_q) begin
							state_q <= S_WEMIT;
						end else begin
							hash_q  <= mrsp.rem;
							wopen_q <= 1'b1;
							state_q <= last_q ? S_FLUSH : S_DONE;
						end
					end
				end
				S_FLUSH: begin
					if (wopen_q) begin
						if (hash_big) begin
							flushing_q <= 1'b1;
							state_q    <= S_DIV;
						end else begin
							state_q    <= S_WEMIT;
						end
					end else begin
						state_q <= last_q ? S_END : S_DONE;
					end
				end
				S_WEMIT: begin
					if (emit_go) begin
						wopen_q <= 1'b0;
						hash_q  <= '0;
						state_q <= last_q ? S_END : S_DONE;
					end
				end
				S_END: begin
					if (emit_go) begin
						inside_q <= 1'b0;
						wopen_q  <= 1'b0;
						hash_q   <= '0;
						tok_q    <= '0;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!hold_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign token_valid = out_v_q;
	assign token_word  = out_q;

	// modulo unit finishes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> state_q == S_DIV)
		else $error("modulo result outside of wait state");

	// reduced value is below the modulus
	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> {1'b0, mrsp.rem} < modulus)
		else $error("modulo result not reduced");

	// no token is left held when a new byte may enter
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !hold_v_q)
		else $error("token held across bytes");

	// a byte is only taken after the previous one has finished
	a_accept_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && $past(state_q != S_IDLE) |-> $past(state_q == S_DONE))
		else $error("sequencer skipped its closing state");

endmodule

// File: rtl/hwt_mod_unit.sv
// Iterative restoring modulo unit, one compare-subtract per cycle.
module hwt_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hwt_pkg::mod_req_t           req,
	input  logic [hwt_pkg::MOD_W-1:0]   modulus,
	output hwt_pkg::mod_rsp_t           rsp
);

	logic [hwt_pkg::REM_W-1:0] rem_q;
	logic [hwt_pkg::K_W-1:0]   k_q;
	logic                      busy_q;
	logic                      done_q;
	logic [hwt_pkg::DSH_W-1:0] dsh;
	logic                      fits;

	// shifted divisor and trial compare
	always_comb begin
		dsh  = {{(hwt_pkg::DSH_W - hwt_pkg::MOD_W){1'b0}}, modulus} << k_q;
		fits = {{(hwt_pkg::DSH_W - hwt_pkg::REM_W){1'b0}}, rem_q} >= dsh;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && (k_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && k_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and step count
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			k_q   <= req.k_start;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh[hwt_pkg::REM_W-1:0];
			end
			if (k_q != '0) begin
				k_q <= k_q - 1'b1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[hwt_pkg::ID_W-1:0];

endmodule
